// ----- design/avi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the accelerometer velocity integrator.
// Used by the front, the command queue, the back and the top level.
package avi_pkg;

  // Field and state widths
  localparam int unsigned SampleW   = 8;
  localparam int unsigned SumW      = 12;
  localparam int unsigned DeadbandW = 10;
  localparam int unsigned GainW     = 24;
  localparam int unsigned PeriodW   = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned SpeedW    = 31;
  localparam int unsigned VelW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;

  // Defaults
  localparam int unsigned WindowLenDefault = 5;
  localparam int unsigned QueueDepth       = 2;

  // Configuration register reset values
  localparam logic [DeadbandW-1:0] DeadbandReset = 10'd15;
  localparam logic [GainW-1:0]     GainReset     = 24'd41428;
  localparam logic [PeriodW-1:0]   PeriodReset   = 8'd8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDeadband = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGain     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod   = 2'd2;

  // Command from the front to the back
  typedef struct packed {
    logic                   integ;    // window closed outside the dead band
    logic                   readout;  // emit a speed readout
    logic signed [SumW-1:0] sum;      // running window sum; the closed window sum when integ is set
  } avi_cmd_t;

endpackage

// ----- design/avi_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and the back.
// Depends on avi_pkg for the command type.
module avi_queue
  import avi_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  avi_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output avi_cmd_t pop_cmd_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  avi_cmd_t            slot_q [Depth];
  logic [AddrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- design/avi_front.sv -----
`timescale 1ns / 1ps
// Front end: takes samples, sums windows, applies the dead band and times
// readouts, then queues commands for the back. Depends on avi_pkg.
module avi_front
  import avi_pkg::*;
#(
  parameter int unsigned WindowLen = WindowLenDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [DeadbandW-1:0]      deadband_i,
  input  logic [PeriodW-1:0]        period_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output avi_cmd_t                  q_cmd_o
);

  localparam int unsigned CntW = $clog2(WindowLen + 1);

  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        win_cnt_q, win_cnt_d;
  logic [PeriodW-1:0]     rd_cnt_q, rd_cnt_d;
  logic                   accept;
  logic signed [SumW-1:0] new_sum;
  logic [SumW-1:0]        mag;
  logic                   close_win;
  logic                   emit;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the sample: window close, dead band, readout
  always_comb begin
    new_sum   = sum_q + SumW'(sample_i);
    mag       = new_sum[SumW-1] ? SumW'(-new_sum) : SumW'(new_sum);
    close_win = (win_cnt_q == CntW'(WindowLen - 1));
    emit      = (rd_cnt_q == (period_i - 1'b1));

    q_cmd_o.integ   = close_win && (mag > SumW'(deadband_i));
    q_cmd_o.readout = emit;
    q_cmd_o.sum     = new_sum;
    q_push_o        = accept && (q_cmd_o.integ || emit);

    sum_d     = sum_q;
    win_cnt_d = win_cnt_q;
    rd_cnt_d  = rd_cnt_q;
    if (accept) begin
      sum_d     = close_win ? '0 : new_sum;
      win_cnt_d = close_win ? '0 : win_cnt_q + 1'b1;
      rd_cnt_d  = emit ? '0 : rd_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      win_cnt_q <= '0;
      rd_cnt_q  <= '0;
    end else begin
      sum_q     <= sum_d;
      win_cnt_q <= win_cnt_d;
      rd_cnt_q  <= rd_cnt_d;
    end
  end

endmodule

// ----- design/avi_back.sv -----
`timescale 1ns / 1ps
// Back end: integrates windows into velocity by the trapezoid rule and
// converts the shown velocity into km/h digits. Depends on avi_pkg.
module avi_back
  import avi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [GainW-1:0]   gain_i,
  input  logic               q_empty_i,
  input  avi_cmd_t           q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DigitW-1:0]  hundreds_digit_o,
  output logic [DigitW-1:0]  tens_digit_o,
  output logic [DigitW-1:0]  units_digit_o,
  output logic [SpeedW-1:0]  speed_value_o
);

  localparam int unsigned ProdW = SumW + 1 + GainW + 1 - 1;  // 13 x 25 signed
  localparam int unsigned AccW  = ProdW + 1 - 8;
  localparam int unsigned QW    = 21;
  localparam int unsigned KmhW  = 10;
  localparam int unsigned RemW  = 7;
  localparam logic [QW-1:0]   KmhSatQ = 21'd10000;
  localparam logic [KmhW-1:0] KmhMax  = 10'd999;

  typedef enum logic [3:0] {
    StIdle, StMul, StAcc, StHalf, StVel, StKmh, StDiv, StDig1, StDig2, StOut
  } state_e;

  state_e                 state_q;
  logic                   readout_q;
  logic signed [VelW-1:0] prior_vel_q, prior_acc_q, shown_q;
  logic                   out_valid_q;
  logic [DigitW-1:0]      hund_out_q, tens_out_q, units_out_q;
  logic [SpeedW-1:0]      speed_out_q;

  // Datapath registers
  logic signed [SumW-1:0]  sum_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [VelW-1:0]  acc_q, half_q;
  logic [QW-1:0]           q_q;
  logic [KmhW-1:0]         kmh_q;
  logic [DigitW-1:0]       hund_q, tens_q;
  logic [RemW-1:0]         rem_q;

  logic signed [SumW:0]    neg_sum;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW:0]   rnd;
  logic signed [VelW:0]    acc_sum;
  logic signed [VelW+1:0]  vel_wide;
  logic signed [VelW-1:0]  vel_sat;
  logic [SpeedW+5:0]       v36;
  logic [29:0]             div_prod;
  logic [15:0]             hund_prod;
  logic [14:0]             tens_prod;
  logic                    out_free;

  assign q_pop_o          = (state_q == StIdle) && !q_empty_i;
  assign out_free         = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign hundreds_digit_o = hund_out_q;
  assign tens_digit_o     = tens_out_q;
  assign units_digit_o    = units_out_q;
  assign speed_value_o    = speed_out_q;

  // Arithmetic of each step
  always_comb begin
    neg_sum   = -$signed({sum_q[SumW-1], sum_q});
    prod_d    = neg_sum * $signed({1'b0, gain_i});
    rnd       = $signed({prod_q[ProdW-1], prod_q}) + (ProdW+1)'(128);
    acc_sum   = $signed({prior_acc_q[VelW-1], prior_acc_q}) +
                $signed({acc_q[VelW-1], acc_q});
    vel_wide  = $signed({{2{prior_vel_q[VelW-1]}}, prior_vel_q}) +
                $signed({{2{half_q[VelW-1]}}, half_q});
    if (vel_wide[VelW+1:VelW-1] == 3'b000 || vel_wide[VelW+1:VelW-1] == 3'b111) begin
      vel_sat = vel_wide[VelW-1:0];
    end else if (vel_wide[VelW+1]) begin
      vel_sat = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      vel_sat = {1'b0, {(VelW-1){1'b1}}};
    end
    v36       = ({6'd0, shown_q[SpeedW-1:0]} << 5) + ({6'd0, shown_q[SpeedW-1:0]} << 2);
    div_prod  = 30'(q_q[13:0]) * 30'd52429;
    hund_prod = 16'(kmh_q) * 16'd41;
    tens_prod = 15'(rem_q) * 15'd205;
  end

  // Sequence commands and hold the velocity state and the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      readout_q   <= 1'b0;
      prior_vel_q <= '0;
      prior_acc_q <= '0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
      hund_out_q  <= '0;
      tens_out_q  <= '0;
      units_out_q <= '0;
      speed_out_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StOut) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (!q_empty_i) begin
            readout_q <= q_cmd_i.readout;
            state_q   <= q_cmd_i.integ ? StMul : StKmh;
          end
        end
        StMul:  state_q <= StAcc;
        StAcc:  state_q <= StHalf;
        StHalf: state_q <= StVel;
        StVel: begin
          prior_vel_q <= vel_sat;
          prior_acc_q <= acc_q;
          shown_q     <= vel_sat[VelW-1] ? '0 : vel_sat;
          state_q     <= readout_q ? StKmh : StIdle;
        end
        StKmh:  state_q <= StDiv;
        StDiv:  state_q <= StDig1;
        StDig1: state_q <= StDig2;
        StDig2: state_q <= StOut;
        StOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            hund_out_q  <= hund_q;
            tens_out_q  <= tens_prod[14:11];
            units_out_q <= DigitW'(rem_q - RemW'(tens_prod[14:11]) * RemW'(10));
            speed_out_q <= shown_q[SpeedW-1:0];
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      sum_q <= q_cmd_i.sum;
    end
    prod_q <= prod_d;
    if (state_q == StAcc) begin
      acc_q <= {{(VelW-AccW+1){rnd[ProdW]}}, rnd[ProdW-1:8]};
    end
    if (state_q == StHalf) begin
      half_q <= acc_sum[VelW:1];
    end
    if (state_q == StKmh) begin
      q_q <= v36[SpeedW+5:16];
    end
    if (state_q == StDiv) begin
      kmh_q <= (q_q >= KmhSatQ) ? KmhMax : div_prod[28:19];
    end
    if (state_q == StDig1) begin
      hund_q <= hund_prod[15:12];
    end
    if (state_q == StDig2) begin
      rem_q <= RemW'(kmh_q - KmhW'(hund_q) * KmhW'(100));
    end
  end

endmodule

// ----- design/accel_velocity_integrator.sv -----
`timescale 1ns / 1ps
// Top level of the accelerometer velocity integrator: configuration
// registers, front end, command queue and back end. Depends on avi_pkg.

// A sample is taken in the cycle it arrives while the two-entry command
// queue has room; the front stalls only when the queue is full. The back
// works one command at a time: a window that closes outside the dead band
// goes through pop, multiply, round, trapezoid half-sum and velocity
// update with saturation, and a readout through scale to km/h, divide by
// ten, the digit steps and the output step, which waits while the output
// register holds a result not yet taken. While the back is busy, the
// front keeps taking samples until the command queue is full.
// Speed is reported as three km/h digits saturated at 999 together with
// the clamped velocity in unsigned Q15.16 m/s.
module accel_velocity_integrator
  import avi_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WindowLenDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [DigitW-1:0]         hundreds_digit_o,
  output logic [DigitW-1:0]         tens_digit_o,
  output logic [DigitW-1:0]         units_digit_o,
  output logic [SpeedW-1:0]         speed_value_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i
);

  logic [DeadbandW-1:0] deadband_q;
  logic [GainW-1:0]     gain_q;
  logic [PeriodW-1:0]   period_q;
  logic                 q_full, q_empty, q_push, q_pop;
  avi_cmd_t             push_cmd, pop_cmd;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DeadbandReset;
      gain_q     <= GainReset;
      period_q   <= PeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDeadband: deadband_q <= cfg_data_i[DeadbandW-1:0];
        CfgGain:     gain_q     <= cfg_data_i[GainW-1:0];
        CfgPeriod:   period_q   <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  avi_front #(
    .WindowLen (WINDOW_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .deadband_i (deadband_q),
    .period_i   (period_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  avi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  avi_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .gain_i           (gain_q),
    .q_empty_i        (q_empty),
    .q_cmd_i          (pop_cmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hundreds_digit_o (hundreds_digit_o),
    .tens_digit_o     (tens_digit_o),
    .units_digit_o    (units_digit_o),
    .speed_value_o    (speed_value_o)
  );

endmodule
